/* sv/dfla_pkg.sv */
// Shared types and constants of the descriptor free-list allocator.
`default_nettype none
package dfla_pkg;

	localparam int HANDLE_W   = 64;
	localparam int STRIDE_W   = 13;
	localparam int SLOT_CNT_W = 11;
	localparam int SLOT_IDX_W = 10;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [STRIDE_W-1:0]   STRIDE_RST   = STRIDE_W'(32);
	localparam int                    SLOT_CNT_RST = 1024;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

	// serial divider: quotient digits per step and step count
	localparam int DIV_DIGIT_W = 4;
	localparam int DIV_STEPS   = HANDLE_W / DIV_DIGIT_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                req_type;
		logic [HANDLE_W-1:0] cpu_handle;
		logic [HANDLE_W-1:0] gpu_handle;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [HANDLE_W-1:0]   out_cpu;
		logic [HANDLE_W-1:0]   out_gpu;
		logic [SLOT_IDX_W-1:0] slot_index;
	} res_t;

	typedef struct packed {
		logic pop;
		logic push;
		logic refill;
	} stk_ctrl_t;

endpackage
`default_nettype wire

/* sv/descriptor_free_list_allocator_core.sv */
// Top level of the descriptor free-list allocator: sequencer, registers, handle math.
//
// Usage:
//   Requests enter on req when start is high and busy is low; one beat is one
//   allocate or free. Every request answers with exactly one result beat on
//   result, marked by done for one cycle. The receiver cannot hold results off.
//   Configuration is written through cfg_we / cfg_idx / cfg_wdata while the
//   block is idle; a write to slot_count refills the free list at once.
// Sequence:
//   allocate: stack read, index times stride, base add, each registered.
//   free: the divider resolves four quotient bits of both handle offsets per
//     cycle over 16 steps.
//   empty allocate or free with zero stride: result registered straight from idle.
//   One request is in flight at a time; busy stays high until its result is
//   registered, and a new request may start in the cycle done is shown.
// Reset:
//   Bases clear, stride is 32, the free list holds min(1024, MAX_SLOTS) slots
//   handing out 0, 1, 2 first. No clearing pass is needed: a low-water mark
//   marks the entries that still hold their refill value.
`default_nettype none
module descriptor_free_list_allocator_core
	import dfla_pkg::*;
#(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire req_t                 req,
	output logic                      busy,
	output logic                      done,
	output res_t                      result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [HANDLE_W-1:0]  cfg_wdata
);

	localparam int AW     = $clog2(MAX_SLOTS);
	localparam int CW     = $clog2(MAX_SLOTS + 1);
	localparam int PROD_W = AW + STRIDE_W;

	localparam logic [1:0] S_IDLE      = 2'd0;
	localparam logic [1:0] S_ALLOC_MUL = 2'd1;
	localparam logic [1:0] S_ALLOC_ADD = 2'd2;
	localparam logic [1:0] S_FREE_DIV  = 2'd3;

	logic [1:0]          state_q;
	logic                done_q;
	res_t                res_q;
	res_t                res_d;
	logic                res_load;

	logic [HANDLE_W-1:0] cpu_base_q, gpu_base_q;
	logic [STRIDE_W-1:0] stride_q;

	logic [AW-1:0]       idx_q;
	logic [PROD_W-1:0]   prod_q;

	stk_ctrl_t           stk_ctrl;
	logic [AW-1:0]       pop_idx;
	logic [CW-1:0]       depth, eff_n, refill_n;

	logic                div_start, div_done;
	logic [HANDLE_W-1:0] quo_cpu, quo_gpu;

	logic                accept, is_free, stack_empty, stride_zero;
	logic                mismatch, out_range, free_ok;

	assign accept      = start && !busy;
	assign is_free     = req.req_type == REQ_FREE;
	assign stack_empty = depth == '0;
	assign stride_zero = stride_q == '0;

	// clamp the written slot count to the stack size
	assign refill_n = (32'(cfg_wdata[SLOT_CNT_W-1:0]) > MAX_SLOTS) ? CW'(MAX_SLOTS)
	                                                               : CW'(cfg_wdata[SLOT_CNT_W-1:0]);

	// free checks on the quotients; the mismatch test wins over range
	assign mismatch  = quo_cpu != quo_gpu;
	assign out_range = (quo_cpu >= HANDLE_W'(eff_n)) || (depth >= eff_n);
	assign free_ok   = !mismatch && !out_range;

	always_comb begin
		stk_ctrl.pop    = accept && !is_free && !stack_empty;
		stk_ctrl.push   = (state_q == S_FREE_DIV) && div_done && free_ok;
		stk_ctrl.refill = cfg_we && (cfg_idx == REG_SLOT_COUNT);
	end

	assign div_start = accept && is_free && !stride_zero;

	dfla_stack #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (stk_ctrl),
		.push_idx (quo_cpu[AW-1:0]),
		.refill_n (refill_n),
		.pop_idx  (pop_idx),
		.depth    (depth),
		.eff_n    (eff_n)
	);

	dfla_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dvd_cpu (req.cpu_handle - cpu_base_q),
		.dvd_gpu (req.gpu_handle - gpu_base_q),
		.divisor (stride_q),
		.done    (div_done),
		.quo_cpu (quo_cpu),
		.quo_gpu (quo_gpu)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_base_q <= '0;
			gpu_base_q <= '0;
			stride_q   <= STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CPU_BASE: cpu_base_q <= cfg_wdata;
				REG_GPU_BASE: gpu_base_q <= cfg_wdata;
				REG_STRIDE:   stride_q   <= cfg_wdata[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// result beat for the current step, zero fields unless set
	always_comb begin
		res_d    = '0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && !is_free && stack_empty) begin
					res_d.status = STAT_EMPTY;
					res_load     = 1'b1;
				end else if (accept && is_free && stride_zero) begin
					res_d.status = STAT_RANGE;
					res_load     = 1'b1;
				end
			end
			S_ALLOC_ADD: begin
				res_d.status     = STAT_OK;
				res_d.out_cpu    = cpu_base_q + HANDLE_W'(prod_q);
				res_d.out_gpu    = gpu_base_q + HANDLE_W'(prod_q);
				res_d.slot_index = SLOT_IDX_W'(idx_q);
				res_load         = 1'b1;
			end
			S_FREE_DIV: begin
				if (div_done) begin
					res_load = 1'b1;
					if (mismatch) begin
						res_d.status = STAT_MISMATCH;
					end else if (out_range) begin
						res_d.status = STAT_RANGE;
					end else begin
						res_d.status     = STAT_OK;
						res_d.slot_index = quo_cpu[SLOT_IDX_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= res_load;
			case (state_q)
				S_IDLE: begin
					if (stk_ctrl.pop) begin
						state_q <= S_ALLOC_MUL;
					end else if (div_start) begin
						state_q <= S_FREE_DIV;
					end
				end
				S_ALLOC_MUL: state_q <= S_ALLOC_ADD;
				S_ALLOC_ADD: state_q <= S_IDLE;
				S_FREE_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: hold the popped index and its offset, load the result beat
	always_ff @(posedge clk) begin
		if (state_q == S_ALLOC_MUL) begin
			idx_q  <= pop_idx;
			prod_q <= PROD_W'(pop_idx) * PROD_W'(stride_q);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

	// the free list never holds more entries than the configured slot count
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth <= eff_n)
		else $error("free-list depth above slot count");

	// a failed request hands out no handle and no index
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |->
			(result.out_cpu == '0 && result.out_gpu == '0 && result.slot_index == '0))
		else $error("failed request returned nonzero fields");

	// the sequencer returns to idle only together with a result beat
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result beat");

endmodule
`default_nettype wire

/* sv/dfla_div.sv */
// Two-lane radix-16 restoring divider of handle offsets by the stride.
`default_nettype none
module dfla_div
	import dfla_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [HANDLE_W-1:0] dvd_cpu,
	input  wire logic [HANDLE_W-1:0] dvd_gpu,
	input  wire logic [STRIDE_W-1:0] divisor,
	output logic                     done,
	output logic [HANDLE_W-1:0]      quo_cpu,
	output logic [HANDLE_W-1:0]      quo_gpu
);

	localparam int DIG_W = STRIDE_W + DIV_DIGIT_W;

	// four dependent restoring steps on a 14-bit partial remainder
	function automatic logic [DIG_W-1:0] div_digit(
		input logic [STRIDE_W-1:0]    rem,
		input logic [DIV_DIGIT_W-1:0] bits,
		input logic [STRIDE_W-1:0]    dvs
	);
		logic [STRIDE_W:0]      t;
		logic [STRIDE_W-1:0]    r;
		logic [DIV_DIGIT_W-1:0] q;
		r = rem;
		q = '0;
		for (int i = DIV_DIGIT_W - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, dvs}) begin
				t    = t - {1'b0, dvs};
				q[i] = 1'b1;
			end
			r = t[STRIDE_W-1:0];
		end
		return {r, q};
	endfunction

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [HANDLE_W-1:0]  a_q, b_q;
	logic [STRIDE_W-1:0]  ra_q, rb_q;
	logic [DIG_W-1:0]     dig_a, dig_b;

	assign dig_a = div_digit(ra_q, a_q[HANDLE_W-1 -: DIV_DIGIT_W], divisor);
	assign dig_b = div_digit(rb_q, b_q[HANDLE_W-1 -: DIV_DIGIT_W], divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient digits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= dvd_cpu;
			b_q  <= dvd_gpu;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			a_q  <= {a_q[HANDLE_W-DIV_DIGIT_W-1:0], dig_a[DIV_DIGIT_W-1:0]};
			b_q  <= {b_q[HANDLE_W-DIV_DIGIT_W-1:0], dig_b[DIV_DIGIT_W-1:0]};
			ra_q <= dig_a[DIG_W-1:DIV_DIGIT_W];
			rb_q <= dig_b[DIG_W-1:DIV_DIGIT_W];
		end
	end

	assign done    = done_q;
	assign quo_cpu = a_q;
	assign quo_gpu = b_q;

endmodule
`default_nettype wire

/* sv/dfla_stack.sv */
// Free-index stack memory with depth pointer and low-water refill tracking.
`default_nettype none
module dfla_stack
	import dfla_pkg::*;
#(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire stk_ctrl_t                          ctrl,
	input  wire logic [$clog2(MAX_SLOTS)-1:0]       push_idx,
	input  wire logic [$clog2(MAX_SLOTS+1)-1:0]     refill_n,
	output logic [$clog2(MAX_SLOTS)-1:0]            pop_idx,
	output logic [$clog2(MAX_SLOTS+1)-1:0]          depth,
	output logic [$clog2(MAX_SLOTS+1)-1:0]          eff_n
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int EFF_RST = (MAX_SLOTS < SLOT_CNT_RST) ? MAX_SLOTS : SLOT_CNT_RST;

	logic [AW-1:0] mem [MAX_SLOTS];
	logic [AW-1:0] rdata_q;
	logic [CW-1:0] depth_q, lw_q, eff_q;
	logic [CW-1:0] top_pos;
	logic [AW-1:0] pos_s1;
	logic          fresh_s1;
	logic [CW-1:0] fresh_val;

	assign top_pos = depth_q - 1'b1;

	// Entries below the low-water mark were never pushed since the last
	// refill, so they still hold their refill value n-1-p.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= CW'(EFF_RST);
			lw_q    <= CW'(EFF_RST);
			eff_q   <= CW'(EFF_RST);
		end else if (ctrl.refill) begin
			depth_q <= refill_n;
			lw_q    <= refill_n;
			eff_q   <= refill_n;
		end else if (ctrl.pop) begin
			depth_q <= top_pos;
			if (top_pos < lw_q) begin
				lw_q <= top_pos;
			end
		end else if (ctrl.push) begin
			depth_q <= depth_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[depth_q[AW-1:0]] <= push_idx;
		end
		if (ctrl.pop) begin
			rdata_q  <= mem[top_pos[AW-1:0]];
			pos_s1   <= top_pos[AW-1:0];
			fresh_s1 <= top_pos < lw_q;
		end
	end

	assign fresh_val = eff_q - 1'b1 - CW'(pos_s1);
	assign pop_idx   = fresh_s1 ? fresh_val[AW-1:0] : rdata_q;
	assign depth     = depth_q;
	assign eff_n     = eff_q;

endmodule
`default_nettype wire

/* dv/descriptor_free_list_allocator_core_test.sv */
// Self-checking testbench of the descriptor free-list allocator core.
`default_nettype none
module descriptor_free_list_allocator_core_test;
	import dfla_pkg::*;

	// Free list depth of the instance; keep in step with the MAX_SLOTS of the dut.
	localparam int          SLOTS         = 1024;
	// Longest request is a free; leave margin on top.
	localparam int          SETTLE_CYCLES = 24;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RAND_PHASES   = 12;
	localparam int          PHASE_BEATS   = 45;

	typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_e;

	// One scheduled action for the driver: a request beat, a register write, or a
	// pause until every awaited result is back.
	typedef struct {
		op_kind_e             kind;
		req_t                 req;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [HANDLE_W-1:0]  wdata;
	} plan_op_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	req_t                 req       = '0;
	logic                 busy;
	logic                 done;
	res_t                 result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [HANDLE_W-1:0]  cfg_wdata = '0;

	plan_op_t op_plan[$];
	res_t     awaited_results[$];

	// issued_cnt is owned by the driver, retired_cnt by the monitor; both move with
	// nonblocking updates so each side sees a stable count at the clock edge.
	int issued_cnt  = 0;
	int retired_cnt = 0;
	int fail_cnt    = 0;
	int reg_writes  = 0;
	int cycle_cnt   = 0;
	int status_seen [4];

	// Driver pacing.
	int idle_run   = 0;
	int gap_left   = 0;
	int burst_left = 0;

	// Allocator shadow: free-list contents, depth and register copies.
	logic [SLOT_IDX_W-1:0] slot_stack [SLOTS];
	int unsigned           stack_fill;
	logic [HANDLE_W-1:0]   cpu_base_q, gpu_base_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [SLOT_CNT_W-1:0] slot_count_q;

	// Generator view of the configuration, used only to build handles.
	logic [HANDLE_W-1:0]   g_cpu_base, g_gpu_base;
	int unsigned           g_stride, g_slots;

	descriptor_free_list_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still awaited", cycle_cnt,
			issued_cnt - retired_cnt);
		$display("descriptor_free_list_allocator_core verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Allocator shadow
	// ------------------------------------------------------------------

	// Slot counts above the list depth behave as the full depth.
	function automatic int unsigned live_slots();
		return (slot_count_q > SLOTS) ? SLOTS : int'(slot_count_q);
	endfunction

	// Restack count-1 at the bottom down to 0 on top, so slot 0 pops first.
	function automatic void refill_slots();
		int unsigned n;
		n = live_slots();
		for (int unsigned i = 0; i < n; i++)
			slot_stack[i] = SLOT_IDX_W'(n - 1 - i);
		stack_fill = n;
	endfunction

	function automatic void write_shadow_reg(logic [CFG_IDX_W-1:0] idx,
			logic [HANDLE_W-1:0] v);
		case (idx)
			REG_CPU_BASE:   cpu_base_q = v;
			REG_GPU_BASE:   gpu_base_q = v;
			REG_STRIDE:     stride_q = v[STRIDE_W-1:0];
			REG_SLOT_COUNT: begin
				slot_count_q = v[SLOT_CNT_W-1:0];
				refill_slots();
			end
			default: ;
		endcase
	endfunction

	// Work out the result beat of one request and advance the shadow free list.
	function automatic res_t predict_slot_result(req_t r);
		res_t                o;
		logic [HANDLE_W-1:0] cpu_q, gpu_q;
		int unsigned         n;
		o = '0;
		n = live_slots();
		if (r.req_type == REQ_ALLOC) begin
			if (stack_fill == 0) begin
				o.status = STAT_EMPTY;
			end else begin
				stack_fill--;
				o.status     = STAT_OK;
				o.slot_index = slot_stack[stack_fill];
				o.out_cpu    = cpu_base_q + HANDLE_W'(o.slot_index) * HANDLE_W'(stride_q);
				o.out_gpu    = gpu_base_q + HANDLE_W'(o.slot_index) * HANDLE_W'(stride_q);
			end
		end else if (stride_q == '0) begin
			// no index can be formed without a stride
			o.status = STAT_RANGE;
		end else begin
			// offsets wrap modulo 2^64 before the truncating divide
			cpu_q = (r.cpu_handle - cpu_base_q) / HANDLE_W'(stride_q);
			gpu_q = (r.gpu_handle - gpu_base_q) / HANDLE_W'(stride_q);
			if (cpu_q != gpu_q) begin
				o.status = STAT_MISMATCH;
			end else if (cpu_q >= HANDLE_W'(n) || stack_fill >= n) begin
				o.status = STAT_RANGE;
			end else begin
				// double frees are not caught: push again while room remains
				slot_stack[stack_fill] = cpu_q[SLOT_IDX_W-1:0];
				stack_fill++;
				o.status     = STAT_OK;
				o.slot_index = cpu_q[SLOT_IDX_W-1:0];
			end
		end
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------

	function automatic logic [HANDLE_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [HANDLE_W-1:0] slot_addr(logic [HANDLE_W-1:0] base,
			int unsigned idx);
		return base + HANDLE_W'(idx) * HANDLE_W'(g_stride);
	endfunction

	// Random skew that stays inside one stride, so truncation lands on the slot.
	function automatic logic [HANDLE_W-1:0] in_slot_skew();
		return (g_stride == 0) ? '0 : HANDLE_W'($urandom_range(0, g_stride - 1));
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_base();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			2:       return rand_word();
			default: return HANDLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic plan_req(logic rtype, logic [HANDLE_W-1:0] cpu,
			logic [HANDLE_W-1:0] gpu);
		plan_op_t op;
		op.kind           = OP_REQ;
		op.req.req_type   = rtype;
		op.req.cpu_handle = cpu;
		op.req.gpu_handle = gpu;
		op.reg_idx        = '0;
		op.wdata          = '0;
		op_plan = {op_plan, op};
	endtask

	task automatic plan_alloc();
		plan_req(REQ_ALLOC, rand_word(), rand_word());
	endtask

	task automatic plan_free_slot(int unsigned idx);
		plan_req(REQ_FREE, slot_addr(g_cpu_base, idx) + in_slot_skew(),
			slot_addr(g_gpu_base, idx) + in_slot_skew());
	endtask

	task automatic plan_reg(logic [CFG_IDX_W-1:0] idx, logic [HANDLE_W-1:0] v);
		plan_op_t op;
		op.kind    = OP_CFG;
		op.req     = '0;
		op.reg_idx = idx;
		op.wdata   = v;
		op_plan = {op_plan, op};
		case (idx)
			REG_CPU_BASE:   g_cpu_base = v;
			REG_GPU_BASE:   g_gpu_base = v;
			REG_STRIDE:     g_stride = int'(v[STRIDE_W-1:0]);
			REG_SLOT_COUNT: g_slots = (v[SLOT_CNT_W-1:0] > SLOTS) ? SLOTS
				: int'(v[SLOT_CNT_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic plan_drain();
		plan_op_t op;
		op.kind    = OP_DRAIN;
		op.req     = '0;
		op.reg_idx = '0;
		op.wdata   = '0;
		op_plan = {op_plan, op};
	endtask

	// ------------------------------------------------------------------
	// Driver: one beat in flight at a time, bursts and gaps at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		logic                 nx_start, nx_we, took;
		req_t                 nx_req;
		logic [CFG_IDX_W-1:0] nx_idx;
		logic [HANDLE_W-1:0]  nx_wdata;
		plan_op_t             op;
		res_t                 nx_res;
		nx_start = start;
		nx_req   = req;
		nx_we    = 1'b0;
		nx_idx   = cfg_idx;
		nx_wdata = cfg_wdata;
		took     = 1'b0;
		if (arst_n) begin
			// Predict at the edge that accepts the beat, in acceptance order.
			if (start && !busy) begin
				nx_res          = predict_slot_result(req);
				awaited_results = {awaited_results, nx_res};
				took            = 1'b1;
			end
			if (issued_cnt == retired_cnt && !start)
				idle_run++;
			else
				idle_run = 0;
			// Hold start and the beat while busy; otherwise pick the next action.
			if (!start || took) begin
				nx_start = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (op_plan.size() > 0) begin
					op = op_plan[0];
					if (op.kind == OP_REQ) begin
						op_plan.pop_front();
						nx_start = 1'b1;
						nx_req   = op.req;
						burst_left--;
						if (burst_left <= 0) begin
							burst_left = $urandom_range(1, 12);
							gap_left   = ($urandom_range(0, 2) == 0) ? 0
								: $urandom_range(1, 20);
						end
					end else if (idle_run >= SETTLE_CYCLES) begin
						// Register writes and pauses only once the block is idle.
						op_plan.pop_front();
						if (op.kind == OP_CFG) begin
							nx_we    = 1'b1;
							nx_idx   = op.reg_idx;
							nx_wdata = op.wdata;
							write_shadow_reg(op.reg_idx, op.wdata);
							reg_writes++;
						end
					end
				end
			end
			if (took)
				issued_cnt <= issued_cnt + 1;
		end
		start     <= nx_start;
		req       <= nx_req;
		cfg_we    <= nx_we;
		cfg_idx   <= nx_idx;
		cfg_wdata <= nx_wdata;
	end

	// ------------------------------------------------------------------
	// Monitor: every done beat retires the oldest awaited result
	// ------------------------------------------------------------------
	task automatic flag_field(string what, logic [HANDLE_W-1:0] want,
			logic [HANDLE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, actual %h", $time, what, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n && done) begin
			if (issued_cnt == retired_cnt) begin
				$display("%0t: result beat expected none, actual %h", $time, result);
				fail_cnt++;
			end else begin
				want = awaited_results.pop_front();
				flag_field("status", HANDLE_W'(want.status), HANDLE_W'(result.status));
				flag_field("out_cpu", want.out_cpu, result.out_cpu);
				flag_field("out_gpu", want.out_gpu, result.out_gpu);
				flag_field("slot_index", HANDLE_W'(want.slot_index),
					HANDLE_W'(result.slot_index));
				status_seen[want.status]++;
				retired_cnt <= retired_cnt + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Plan, reset, drain, verdict
	// ------------------------------------------------------------------
	initial begin : run
		int          alloc_pct, drain_at, pick;
		int unsigned idx;

		foreach (status_seen[i]) status_seen[i] = 0;

		// Shadow and generator start from the reset configuration.
		cpu_base_q   = '0;
		gpu_base_q   = '0;
		stride_q     = STRIDE_RST;
		slot_count_q = SLOT_CNT_W'(SLOT_CNT_RST);
		refill_slots();
		g_cpu_base = '0;
		g_gpu_base = '0;
		g_stride   = int'(STRIDE_RST);
		g_slots    = (SLOT_CNT_RST > SLOTS) ? SLOTS : SLOT_CNT_RST;

		// Reset layout: slots 0 and 1 go out first.
		plan_alloc();
		plan_alloc();
		plan_req(REQ_FREE, 64'd32, 64'd63);            // truncation to slot 1
		plan_req(REQ_FREE, 64'd37, 64'd32);            // double free of slot 1 fits
		plan_req(REQ_FREE, 64'd0, 64'd0);              // list full
		plan_alloc();                                  // slot 1 comes back first
		plan_req(REQ_FREE, 64'd0, 64'd32);             // pair disagrees
		plan_req(REQ_FREE, '1, '1);                    // index far out of range
		plan_req(REQ_FREE, '0, '1);

		// Two slots, unit stride, CPU base at the top so handles wrap.
		// Upper write-data bits are junk that the narrow registers must drop.
		plan_reg(REG_CPU_BASE, '1);
		plan_reg(REG_GPU_BASE, 64'h8000_0000_0000_0000);
		plan_reg(REG_STRIDE, 64'hFFFF_FFFF_FFFF_E001);
		plan_reg(REG_SLOT_COUNT, 64'hFFFF_FFFF_FFFF_F802);
		plan_alloc();
		plan_alloc();
		plan_alloc();                                  // empty
		plan_free_slot(1);
		plan_free_slot(0);
		plan_free_slot(0);                             // full again

		// Zero stride: allocate hands out the bases, free cannot form an index.
		plan_reg(REG_STRIDE, 64'hA5A5_A5A5_A5A5_C000);
		plan_alloc();
		plan_req(REQ_FREE, rand_word(), rand_word());

		// Widest stride and an oversize count that folds to the full depth.
		plan_reg(REG_CPU_BASE, rand_word());
		plan_reg(REG_GPU_BASE, rand_word());
		plan_reg(REG_STRIDE, 64'h1FFF);
		plan_reg(REG_SLOT_COUNT, 64'h7FF);
		plan_alloc();
		plan_free_slot(SLOTS - 1);
		plan_free_slot(SLOTS);

		// No slots at all.
		plan_reg(REG_SLOT_COUNT, 64'h0);
		plan_alloc();
		plan_free_slot(0);

		plan_reg(REG_SLOT_COUNT, 64'h400);
		plan_reg(REG_STRIDE, 64'h1000);
		plan_alloc();
		plan_free_slot(SLOTS - 1);

		// Random phases: mostly allocate and free of slots in range with random
		// skew, plus mismatched pairs, out-of-range and raw handles as noise.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if ($urandom_range(0, 2) != 0)
				plan_reg(REG_CPU_BASE, pick_base());
			if ($urandom_range(0, 2) != 0)
				plan_reg(REG_GPU_BASE, pick_base());
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       idx = 0;
					1:       idx = 8191;
					2:       idx = 4096;
					default: idx = $urandom_range(1, 48);
				endcase
				plan_reg(REG_STRIDE, {rand_word()} & ~64'h1FFF | HANDLE_W'(idx));
			end
			if (ph == 0 || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       idx = 0;
					1:       idx = 1024;
					2:       idx = $urandom_range(1025, 2047);
					default: idx = $urandom_range(1, 20);
				endcase
				plan_reg(REG_SLOT_COUNT, {rand_word()} & ~64'h7FF | HANDLE_W'(idx));
			end
			alloc_pct = $urandom_range(25, 65);
			drain_at  = (ph == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(5, 40) : -1;
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (k == drain_at)
					plan_drain();
				if ($urandom_range(0, 99) < alloc_pct) begin
					plan_alloc();
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 75) begin
						plan_free_slot((g_slots == 0) ? 0 : $urandom_range(0, g_slots - 1));
					end else if (pick < 85) begin
						idx = $urandom_range(0, g_slots + 1);
						plan_req(REQ_FREE, slot_addr(g_cpu_base, idx) + in_slot_skew(),
							slot_addr(g_gpu_base, idx + 1 + $urandom_range(0, 2)));
					end else if (pick < 93) begin
						plan_free_slot(g_slots + $urandom_range(0, 3));
					end else begin
						plan_req(REQ_FREE, rand_word(), rand_word());
					end
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait out the plan and the last beat, then give stray results a chance.
		while (op_plan.size() != 0 || start || issued_cnt != retired_cnt)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d requests across %0d register writes", retired_cnt, reg_writes);
		$display("results: %0d ok, %0d empty, %0d pair mismatch, %0d range or full",
			status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_MISMATCH],
			status_seen[STAT_RANGE]);
		if (fail_cnt == 0)
			$display("descriptor_free_list_allocator_core verification clean");
		else
			$display("descriptor_free_list_allocator_core verification failed");
		$finish;
	end

endmodule
`default_nettype wire
